// File: rtl/rcspc_pkg.sv
// Package for the RC servo pulse width capture block.
// Holds the item structs, register index codes and reset constants.
// No dependencies.
package rcspc_pkg;

   localparam int CHANNELS   = 7;
   localparam int CHAN_W     = 3;
   localparam int PIN_W      = 7;
   localparam int COUNT_W    = 16;
   localparam int TICK_W     = 8;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 16;

   localparam logic [COUNT_W-1:0] COUNTER_TOP_RST   = 16'd65535;
   localparam logic [TICK_W-1:0]  TICK_DURATION_RST = 8'd2;
   localparam logic [COUNT_W-1:0] UPPER_WIDTH_RST   = 16'd2100;
   localparam logic [COUNT_W-1:0] LOWER_WIDTH_RST   = 16'd900;
   localparam logic [COUNT_W-1:0] HELD_WIDTH_RST    = 16'd1500;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_COUNTER_TOP   = 2'd0,
      CSR_TICK_DURATION = 2'd1,
      CSR_UPPER_WIDTH   = 2'd2,
      CSR_LOWER_WIDTH   = 2'd3
   } csr_index_type;

   typedef struct packed {
      logic [PIN_W-1:0]   pins;
      logic [COUNT_W-1:0] timer_count;
   } req_item_type;

   typedef struct packed {
      logic [CHAN_W-1:0]  channel;
      logic [COUNT_W-1:0] width;
      logic               accepted;
      logic [COUNT_W-1:0] held_width;
      logic               last;
   } rsp_item_type;

endpackage

// File: rtl/rc_servo_pulse_width_capture.sv
// Top level of the RC servo pulse width capture block.
// Depends on rcspc_pkg for item structs, register codes and constants.
//
// channel  dir  handshake               payload
// req_     in   req_valid / req_stall   req_item  (pins, timer_count)
// rsp_     out  rsp_valid / rsp_stall   rsp_item  (channel, width, accepted, held_width, last)
// csr_     in   csr_we                  csr_index, csr_wdata
//
// An item is taken in any cycle with no falling edge pending. An item with falling edges
// holds the measure register until each has a result: the single tick multiplier turns
// out one result per cycle while the result register is not stalled, lowest channel
// first, and the next item is taken in the cycle the last of them moves to the result
// register. Reset is synchronous and restores registers, start counts and held widths.
// A stalled result register holds; the measure stage, and input with edges pending, wait.
module rc_servo_pulse_width_capture
   import rcspc_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  req_item_type          req_item,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output rsp_item_type          rsp_item,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   logic [COUNT_W-1:0] counter_top_ff;
   logic [TICK_W-1:0]  tick_duration_ff;
   logic [COUNT_W-1:0] upper_width_ff;
   logic [COUNT_W-1:0] lower_width_ff;

   logic [PIN_W-1:0]   prev_pins_ff;
   logic [COUNT_W-1:0] start_count_ff [CHANNELS];
   logic [COUNT_W-1:0] held_width_ff  [CHANNELS];

   // measure stage: falling edges still to report and the sample time
   logic [CHANNELS-1:0] pend_ff, pend_in;
   logic [COUNT_W-1:0]  now_ff;

   logic                rsp_valid_ff;
   rsp_item_type        rsp_item_ff, rsp_item_in;

   logic                advance, fire, accept;
   logic [CHAN_W-1:0]   sel;
   logic [CHANNELS-1:0] sel_onehot, rest;
   logic [COUNT_W-1:0]  start_sel, ticks, width;
   logic [COUNT_W+TICK_W-1:0] product;
   logic                ok;
   logic [CHANNELS-1:0] pins_now, rising, falling;

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         counter_top_ff   <= COUNTER_TOP_RST;
         tick_duration_ff <= TICK_DURATION_RST;
         upper_width_ff   <= UPPER_WIDTH_RST;
         lower_width_ff   <= LOWER_WIDTH_RST;
      end else if (csr_we) begin
         case (csr_index)
            CSR_COUNTER_TOP:   counter_top_ff   <= csr_wdata;
            CSR_TICK_DURATION: tick_duration_ff <= csr_wdata[TICK_W-1:0];
            CSR_UPPER_WIDTH:   upper_width_ff   <= csr_wdata;
            CSR_LOWER_WIDTH:   lower_width_ff   <= csr_wdata;
            default: ;
         endcase
      end
   end

   // pick the lowest pending falling edge
   always_comb begin
      sel = '0;
      for (int i = CHANNELS - 1; i >= 0; i--) begin
         if (pend_ff[i]) begin
            sel = CHAN_W'(i);
         end
      end
      sel_onehot = '0;
      sel_onehot[sel] = pend_ff[sel];
      rest = pend_ff & ~sel_onehot;
   end

   assign advance = !rsp_valid_ff || !rsp_stall;
   assign fire    = (pend_ff != '0) && advance;
   assign req_stall = (pend_ff != '0) && !(fire && (rest == '0));
   assign accept  = req_valid && !req_stall;

   assign pins_now = req_item.pins[CHANNELS-1:0];
   assign rising   = pins_now & ~prev_pins_ff[CHANNELS-1:0];
   assign falling  = ~pins_now & prev_pins_ff[CHANNELS-1:0];

   // elapsed ticks, scaled to microseconds, range check
   always_comb begin
      start_sel = start_count_ff[sel];
      if (now_ff < start_sel) begin
         ticks = now_ff + counter_top_ff - start_sel;
      end else begin
         ticks = now_ff - start_sel;
      end
      product = ticks * tick_duration_ff;
      width   = product[COUNT_W-1:0];
      ok      = !(width > upper_width_ff || width < lower_width_ff);

      rsp_item_in.channel    = sel;
      rsp_item_in.width      = width;
      rsp_item_in.accepted   = ok;
      rsp_item_in.held_width = ok ? width : held_width_ff[sel];
      rsp_item_in.last       = (rest == '0);
   end

   always_comb begin
      pend_in = pend_ff;
      if (accept) begin
         pend_in = falling;
      end else if (fire) begin
         pend_in = rest;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_pins_ff <= '0;
         pend_ff      <= '0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < CHANNELS; i++) begin
            start_count_ff[i] <= '0;
            held_width_ff[i]  <= HELD_WIDTH_RST;
         end
      end else begin
         pend_ff <= pend_in;
         if (accept) begin
            prev_pins_ff <= req_item.pins;
            for (int i = 0; i < CHANNELS; i++) begin
               if (rising[i]) begin
                  start_count_ff[i] <= req_item.timer_count;
               end
            end
         end
         if (fire && ok) begin
            held_width_ff[sel] <= width;
         end
         if (advance) begin
            rsp_valid_ff <= fire;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (accept) begin
         now_ff <= req_item.timer_count;
      end
      if (fire) begin
         rsp_item_ff <= rsp_item_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_item_ff;

endmodule

// File: sim/tb_rc_servo_pulse_width_capture.sv
// Testbench for rc_servo_pulse_width_capture: directed samples, then random pin traffic
// over several register settings, each result checked against a listed expected value or an in-bench predictor.
// Depends on rcspc_pkg and the rc_servo_pulse_width_capture RTL.
`timescale 1ns / 100ps

module tb_rc_servo_pulse_width_capture;
   import rcspc_pkg::*;

   localparam int DIR_ROWS = 22;
   localparam int PHASES   = 7;
   localparam int PER_PHASE = 57;
   localparam int SETTLE   = 16;
   localparam rsp_item_type NO_RSP = '0;

   typedef struct {
      logic [PIN_W-1:0]   pins;
      logic [COUNT_W-1:0] tcount;
      bit                 typed;
      rsp_item_type       want;
   } sample_row_type;

   logic                  clock = 1'b0;
   logic                  reset;
   logic                  req_valid;
   logic                  req_stall;
   req_item_type          req_item;
   logic                  rsp_valid;
   logic                  rsp_stall;
   rsp_item_type          rsp_item;
   logic                  csr_we;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   // predictor state and its copy of the registers
   logic [PIN_W-1:0]   pin_hist;
   logic [COUNT_W-1:0] pulse_start [CHANNELS];
   logic [COUNT_W-1:0] held_us [CHANNELS];
   logic [COUNT_W-1:0] cfg_top;
   logic [TICK_W-1:0]  cfg_tick;
   logic [COUNT_W-1:0] cfg_upper;
   logic [COUNT_W-1:0] cfg_lower;

   rsp_item_type sample_out [$];
   rsp_item_type pending_widths [$];
   int           rsp_seen   = 0;
   int           fail_count = 0;
   int           idle_pct   = 30;

   rc_servo_pulse_width_capture dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_item  (req_item),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_item  (rsp_item),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always #5 clock = ~clock;

   initial begin
      #10_000_000;
      $display("tb_rc_servo_pulse_width_capture NOT OK");
      $finish;
   end

   function automatic int idle_len();
      if ($urandom_range(0, 99) >= idle_pct) return 0;
      if ($urandom_range(0, 9) == 0) return $urandom_range(10, 40);
      return $urandom_range(1, 3);
   endfunction

   // Work out the results of one sample: starts on rising edges, widths on falling edges.
   function automatic void capture_sample(input req_item_type it);
      logic [PIN_W-1:0] rise, fall;
      logic [31:0]      ticks, prod;
      rsp_item_type     r;
      rise = it.pins & ~pin_hist;
      fall = ~it.pins & pin_hist;
      sample_out.delete();
      for (int i = 0; i < CHANNELS; i++)
         if (rise[i]) pulse_start[i] = it.timer_count;
      for (int i = 0; i < CHANNELS; i++) begin
         if (fall[i]) begin
            if (it.timer_count < pulse_start[i])
               ticks = (32'(it.timer_count) + 32'(cfg_top) - 32'(pulse_start[i])) & 32'hFFFF;
            else
               ticks = 32'(it.timer_count) - 32'(pulse_start[i]);
            prod = ticks * 32'(cfg_tick);
            r.channel  = 3'(i);
            r.width    = prod[15:0];
            r.accepted = !(r.width > cfg_upper || r.width < cfg_lower);
            if (r.accepted) held_us[i] = r.width;
            r.held_width = held_us[i];
            r.last       = 1'b0;
            sample_out.push_back(r);
         end
      end
      if (sample_out.size() > 0) sample_out[sample_out.size()-1].last = 1'b1;
      pin_hist = it.pins;
   endfunction

   task automatic offer(input req_item_type it, input bit typed, input rsp_item_type want);
      int gap;
      gap = idle_len();
      @(negedge clock);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_item  <= it;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      capture_sample(it);
      if (typed)
         pending_widths.push_back(want);
      else
         foreach (sample_out[k]) pending_widths.push_back(sample_out[k]);
   endtask

   task automatic write_reg(input csr_index_type idx, input logic [CSR_DATA_W-1:0] val);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      case (idx)
         CSR_COUNTER_TOP:   cfg_top   = val;
         CSR_TICK_DURATION: cfg_tick  = val[TICK_W-1:0];
         CSR_UPPER_WIDTH:   cfg_upper = val;
         CSR_LOWER_WIDTH:   cfg_lower = val;
         default: ;
      endcase
   endtask

   task automatic retune(input logic [15:0] top, tick, upper, lower);
      write_reg(CSR_COUNTER_TOP, top);
      write_reg(CSR_TICK_DURATION, tick);
      write_reg(CSR_UPPER_WIDTH, upper);
      write_reg(CSR_LOWER_WIDTH, lower);
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   // Hold the sender until every expected result is back, then let trailing items settle.
   task automatic drain();
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_widths.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   // Receiver: random stalls, plus one long hold-off to back the block up.
   initial begin : rx
      int  hold;
      bit  held_once;
      hold      = 0;
      held_once = 0;
      rsp_stall = 1'b0;
      forever begin
         @(negedge clock);
         if (!held_once && rsp_seen >= 60) begin
            held_once = 1;
            hold      = 400;
         end
         if (hold == 0) hold = idle_len();
         if (hold > 0) begin
            rsp_stall <= 1'b1;
            hold--;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin : watch
      rsp_item_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         rsp_seen++;
         if (pending_widths.size() == 0) begin
            $error("unexpected result: channel %0d width %0d", rsp_item.channel, rsp_item.width);
            fail_count++;
         end else begin
            want = pending_widths.pop_front();
            if (rsp_item.channel !== want.channel) begin
               $error("channel: expected %0d, got %0d", want.channel, rsp_item.channel);
               fail_count++;
            end
            if (rsp_item.width !== want.width) begin
               $error("width: expected %0d, got %0d", want.width, rsp_item.width);
               fail_count++;
            end
            if (rsp_item.accepted !== want.accepted) begin
               $error("accepted: expected %0d, got %0d", want.accepted, rsp_item.accepted);
               fail_count++;
            end
            if (rsp_item.held_width !== want.held_width) begin
               $error("held_width: expected %0d, got %0d", want.held_width,
                      rsp_item.held_width);
               fail_count++;
            end
            if (rsp_item.last !== want.last) begin
               $error("last: expected %0d, got %0d", want.last, rsp_item.last);
               fail_count++;
            end
         end
      end
   end

   initial begin : stim
      sample_row_type     dir_rows [DIR_ROWS];
      logic [15:0]        plan [PHASES][4];
      int                 phase_idle [PHASES];
      req_item_type       it;
      logic [PIN_W-1:0]   pin_now, flips;
      logic [COUNT_W-1:0] tick_now;
      logic [15:0]        lo;

      reset     = 1'b1;
      req_valid = 1'b0;
      req_item  = '0;
      csr_we    = 1'b0;
      csr_index = '0;
      csr_wdata = '0;

      pin_hist  = '0;
      cfg_top   = COUNTER_TOP_RST;
      cfg_tick  = TICK_DURATION_RST;
      cfg_upper = UPPER_WIDTH_RST;
      cfg_lower = LOWER_WIDTH_RST;
      for (int i = 0; i < CHANNELS; i++) begin
         pulse_start[i] = '0;
         held_us[i]     = HELD_WIDTH_RST;
      end

      // pins, count, typed, expected result (channel, width, accepted, held, last)
      dir_rows = '{
         '{7'h00, 16'd0,     1'b0, NO_RSP},
         '{7'h01, 16'd100,   1'b0, NO_RSP},
         '{7'h00, 16'd600,   1'b1, '{3'd0, 16'd1000, 1'b1, 16'd1000, 1'b1}},
         '{7'h02, 16'd1000,  1'b0, NO_RSP},
         '{7'h00, 16'd1300,  1'b1, '{3'd1, 16'd600, 1'b0, 16'd1500, 1'b1}},
         '{7'h04, 16'd2000,  1'b0, NO_RSP},
         '{7'h00, 16'd3050,  1'b1, '{3'd2, 16'd2100, 1'b1, 16'd2100, 1'b1}},
         '{7'h08, 16'd4000,  1'b0, NO_RSP},
         '{7'h00, 16'd4450,  1'b1, '{3'd3, 16'd900, 1'b1, 16'd900, 1'b1}},
         '{7'h10, 16'd5000,  1'b0, NO_RSP},
         '{7'h00, 16'd6051,  1'b1, '{3'd4, 16'd2102, 1'b0, 16'd1500, 1'b1}},
         '{7'h20, 16'd65000, 1'b0, NO_RSP},
         '{7'h00, 16'd200,   1'b0, NO_RSP},
         '{7'h7F, 16'd10000, 1'b0, NO_RSP},
         '{7'h00, 16'd10700, 1'b0, NO_RSP},
         '{7'h7F, 16'd65535, 1'b0, NO_RSP},
         '{7'h7F, 16'd0,     1'b0, NO_RSP},
         '{7'h55, 16'd500,   1'b0, NO_RSP},
         '{7'h2A, 16'd1000,  1'b0, NO_RSP},
         '{7'h00, 16'd0,     1'b0, NO_RSP},
         '{7'h40, 16'd0,     1'b0, NO_RSP},
         '{7'h00, 16'd0,     1'b0, NO_RSP}
      };

      // counter_top, tick_duration, upper_width, lower_width
      plan = '{
         '{16'd65535, 16'd2,   16'd2100,  16'd900},
         '{16'd1000,  16'd1,   16'd65535, 16'd0},
         '{16'd65535, 16'd255, 16'd65535, 16'd0},
         '{16'd1,     16'd2,   16'd2100,  16'd900},
         '{16'd0,     16'd0,   16'd0,     16'd0},
         '{16'd20000, 16'd3,   16'd1000,  16'd3000},
         '{16'd0,     16'd0,   16'd0,     16'd0}
      };
      phase_idle = '{40, 25, 0, 50, 30, 40, 35};

      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      for (int r = 0; r < DIR_ROWS; r++) begin
         it.pins        = dir_rows[r].pins;
         it.timer_count = dir_rows[r].tcount;
         offer(it, dir_rows[r].typed, dir_rows[r].want);
      end
      drain();

      pin_now  = pin_hist;
      tick_now = 16'd0;
      for (int p = 0; p < PHASES; p++) begin
         if (p == PHASES - 1) begin
            lo = 16'($urandom_range(0, 2000));
            plan[p] = '{16'($urandom_range(1, 65535)), 16'($urandom_range(1, 255)),
                        lo + 16'($urandom_range(0, 4000)), lo};
         end
         retune(plan[p][0], plan[p][1], plan[p][2], plan[p][3]);
         idle_pct = phase_idle[p];
         for (int n = 0; n < PER_PHASE; n++) begin
            if ($urandom_range(0, 99) < 15) begin
               // noise: jump anywhere
               pin_now  = 7'($urandom_range(0, 127));
               tick_now = 16'($urandom_range(0, 65535));
            end else begin
               if ($urandom_range(0, 9) == 0)
                  tick_now = tick_now + 16'($urandom_range(0, 65535));
               else
                  tick_now = tick_now + 16'($urandom_range(40, 700));
               flips = '0;
               for (int i = 0; i < CHANNELS; i++)
                  if ($urandom_range(0, 3) == 0) flips[i] = 1'b1;
               if ($urandom_range(0, 19) == 0) flips = '1;
               pin_now = pin_now ^ flips;
            end
            it.pins        = pin_now;
            it.timer_count = tick_now;
            offer(it, 1'b0, NO_RSP);
         end
         drain();
      end

      if (fail_count == 0)
         $display("tb_rc_servo_pulse_width_capture OK");
      else
         $display("tb_rc_servo_pulse_width_capture NOT OK");
      $finish;
   end

endmodule

// File: files.f
rtl/rcspc_pkg.sv
rtl/rc_servo_pulse_width_capture.sv
sim/tb_rc_servo_pulse_width_capture.sv
